@@ design/fatct_pkg.sv @@
// Shared types and constants of the FAT12 cluster table engine.
// No dependencies; every other design file uses it by scoped names.
package fatct_pkg;

   localparam int MAX_CLUSTERS = 4096;
   localparam int TABLE_BYTES  = (MAX_CLUSTERS * 3) / 2;
   // Even and odd bytes of the table sit in two banks, so both bytes of an entry
   // come out in one access.
   localparam int BANK_DEPTH   = TABLE_BYTES / 2;
   localparam int BANK_AW      = $clog2(BANK_DEPTH);

   localparam int CMD_W        = 3;
   localparam int CLUSTER_W    = 12;
   localparam int COUNT_W      = 13;
   localparam int BADDR_W      = 13;
   localparam int BYTE_W       = 8;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   localparam logic [CMD_W-1:0] CMD_GET_NEXT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_NEXT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_END    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND_FREE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FREE_CHAIN = 3'd4;
   localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ_BYTE  = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STEP_LIMIT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAIN_END_LIMIT = 2'd1;

   localparam logic [CLUSTER_W-1:0] EOC_MARK           = 12'hFFF;
   localparam logic [COUNT_W-1:0]   RESET_CLUSTER_COUNT = 13'd4096;
   localparam logic [CLUSTER_W-1:0] RESET_CHAIN_END     = 12'd4088;
   localparam logic [COUNT_W-1:0]   FIRST_DATA_CLUSTER  = 13'd2;

   typedef enum logic [1:0] {
      WV_NEXT = 2'd0,
      WV_EOC  = 2'd1,
      WV_ZERO = 2'd2
   } wr_val_type;

   typedef enum logic [2:0] {
      RES_ZERO       = 3'd0,
      RES_ENTRY      = 3'd1,
      RES_BYTE       = 3'd2,
      RES_FREE       = 3'd3,
      RES_NO_FREE    = 3'd4,
      RES_STEP_LIMIT = 3'd5
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        addr_byte;
      logic        mem_rd;
      logic        wr_entry;
      wr_val_type  wr_val_sel;
      logic        wr_byte;
      logic        mem_clear;
      logic        cur_two;
      logic        cur_inc;
      logic        cur_next;
      logic        steps_inc;
      logic        res_load;
      res_sel_type res_sel;
      logic        out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             clear_last;
      logic             cur_below_count;
      logic             entry_zero;
      logic             chain_go;
      logic             steps_at_limit;
      logic             out_busy;
   } ctrl_status_type;

endpackage

@@ design/fatct_intf.sv @@
// Request, response and register-write channel interfaces of the engine.
// Depends on fatct_pkg for field widths.
interface fatct_req_if;
   logic                              valid;
   logic                              ready;
   logic [fatct_pkg::CMD_W-1:0]       cmd;
   logic [fatct_pkg::CLUSTER_W-1:0]   cluster;
   logic [fatct_pkg::CLUSTER_W-1:0]   next_value;
   logic [fatct_pkg::BADDR_W-1:0]     byte_addr;
   logic [fatct_pkg::BYTE_W-1:0]      byte_data;
   modport source (output valid, cmd, cluster, next_value, byte_addr, byte_data,
                   input ready);
   modport sink   (input valid, cmd, cluster, next_value, byte_addr, byte_data,
                   output ready);
endinterface

interface fatct_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fatct_pkg::CLUSTER_W-1:0]   entry_value;
   logic [fatct_pkg::BYTE_W-1:0]      byte_value;
   logic [fatct_pkg::STATUS_W-1:0]    status;
   modport source (output valid, entry_value, byte_value, status, input ready);
   modport sink   (input valid, entry_value, byte_value, status, output ready);
endinterface

interface fatct_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fatct_pkg::CSR_IDX_W-1:0]   index;
   logic [fatct_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/fatct_ctrl.sv @@
// Sequencer of the cluster table engine: clear pass, command dispatch, walks.
// Depends on fatct_pkg; drives fatct_datapath through the command struct.
module fatct_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fatct_pkg::ctrl_status_type sts,
   output fatct_pkg::ctrl_cmd_type    cmd_o
);

   typedef enum logic [10:0] {
      S_CLEAR   = 11'b000_0000_0001,
      S_IDLE    = 11'b000_0000_0010,
      S_DISP    = 11'b000_0000_0100,
      S_GET_CHK = 11'b000_0000_1000,
      S_SET_WR  = 11'b000_0001_0000,
      S_BR_CHK  = 11'b000_0010_0000,
      S_FF_EVAL = 11'b000_0100_0000,
      S_FF_CHK  = 11'b000_1000_0000,
      S_FC_EVAL = 11'b001_0000_0000,
      S_FC_CHK  = 11'b010_0000_0000,
      S_DONE    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd_o.mem_clear = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.load_req = 1'b1;
               state_in       = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.cmd)
               fatct_pkg::CMD_GET_NEXT: begin
                  cmd_o.mem_rd = 1'b1;
                  state_in     = S_GET_CHK;
               end
               fatct_pkg::CMD_SET_NEXT, fatct_pkg::CMD_SET_END: begin
                  cmd_o.mem_rd = 1'b1;
                  state_in     = S_SET_WR;
               end
               fatct_pkg::CMD_FIND_FREE: begin
                  cmd_o.cur_two = 1'b1;
                  state_in      = S_FF_EVAL;
               end
               fatct_pkg::CMD_FREE_CHAIN: begin
                  state_in = S_FC_EVAL;
               end
               fatct_pkg::CMD_WRITE_BYTE: begin
                  cmd_o.wr_byte  = 1'b1;
                  cmd_o.res_load = 1'b1;
                  cmd_o.res_sel  = fatct_pkg::RES_ZERO;
                  state_in       = S_DONE;
               end
               fatct_pkg::CMD_READ_BYTE: begin
                  cmd_o.mem_rd    = 1'b1;
                  cmd_o.addr_byte = 1'b1;
                  state_in        = S_BR_CHK;
               end
               default: begin
                  cmd_o.res_load = 1'b1;
                  cmd_o.res_sel  = fatct_pkg::RES_ZERO;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_GET_CHK: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = fatct_pkg::RES_ENTRY;
            state_in       = S_DONE;
         end
         S_SET_WR: begin
            cmd_o.wr_entry   = 1'b1;
            cmd_o.wr_val_sel = (sts.cmd == fatct_pkg::CMD_SET_END) ?
                               fatct_pkg::WV_EOC : fatct_pkg::WV_NEXT;
            cmd_o.res_load   = 1'b1;
            cmd_o.res_sel    = fatct_pkg::RES_ZERO;
            state_in         = S_DONE;
         end
         S_BR_CHK: begin
            cmd_o.addr_byte = 1'b1;
            cmd_o.res_load  = 1'b1;
            cmd_o.res_sel   = fatct_pkg::RES_BYTE;
            state_in        = S_DONE;
         end
         S_FF_EVAL: begin
            if (sts.cur_below_count) begin
               cmd_o.mem_rd = 1'b1;
               state_in     = S_FF_CHK;
            end else begin
               cmd_o.res_load = 1'b1;
               cmd_o.res_sel  = fatct_pkg::RES_NO_FREE;
               state_in       = S_DONE;
            end
         end
         S_FF_CHK: begin
            if (sts.entry_zero) begin
               cmd_o.res_load = 1'b1;
               cmd_o.res_sel  = fatct_pkg::RES_FREE;
               state_in       = S_DONE;
            end else begin
               cmd_o.cur_inc = 1'b1;
               state_in      = S_FF_EVAL;
            end
         end
         S_FC_EVAL: begin
            if (!sts.chain_go) begin
               cmd_o.res_load = 1'b1;
               cmd_o.res_sel  = fatct_pkg::RES_ZERO;
               state_in       = S_DONE;
            end else if (sts.steps_at_limit) begin
               cmd_o.res_load = 1'b1;
               cmd_o.res_sel  = fatct_pkg::RES_STEP_LIMIT;
               state_in       = S_DONE;
            end else begin
               cmd_o.mem_rd = 1'b1;
               state_in     = S_FC_CHK;
            end
         end
         S_FC_CHK: begin
            // free this link and follow the value it held
            cmd_o.wr_entry   = 1'b1;
            cmd_o.wr_val_sel = fatct_pkg::WV_ZERO;
            cmd_o.cur_next   = 1'b1;
            cmd_o.steps_inc  = 1'b1;
            state_in         = S_FC_EVAL;
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd_o.out_load = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd_o.load_req |=> state_ff == S_DISP)
      else $error("accepted request not dispatched");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      cmd_o.res_load |=> state_ff == S_DONE)
      else $error("result loaded but not handed on");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |-> !sts.out_busy)
      else $error("output register overwritten while held");

   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      cmd_o.mem_rd |-> !(cmd_o.wr_entry || cmd_o.wr_byte || cmd_o.mem_clear))
      else $error("read and write issued together");

endmodule

@@ design/fatct_datapath.sv @@
// Datapath of the cluster table engine: two byte banks, entry pack/unpack,
// cursor and step counters, registers and the response register.
// Depends on fatct_pkg; steered by fatct_ctrl.
module fatct_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fatct_pkg::CMD_W-1:0]       req_cmd,
   input  logic [fatct_pkg::CLUSTER_W-1:0]   req_cluster,
   input  logic [fatct_pkg::CLUSTER_W-1:0]   req_next_value,
   input  logic [fatct_pkg::BADDR_W-1:0]     req_byte_addr,
   input  logic [fatct_pkg::BYTE_W-1:0]      req_byte_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fatct_pkg::CLUSTER_W-1:0]   rsp_entry_value,
   output logic [fatct_pkg::BYTE_W-1:0]      rsp_byte_value,
   output logic [fatct_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                              csr_we,
   input  logic [fatct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fatct_pkg::CSR_DATA_W-1:0]  csr_data,
   input  fatct_pkg::ctrl_cmd_type           cmd_i,
   output fatct_pkg::ctrl_status_type        sts_o
);

   localparam logic [fatct_pkg::BADDR_W-1:0] TB_LIMIT =
      fatct_pkg::BADDR_W'(fatct_pkg::TABLE_BYTES);
   localparam logic [fatct_pkg::COUNT_W-1:0] MAX_COUNT =
      fatct_pkg::COUNT_W'(fatct_pkg::MAX_CLUSTERS);
   localparam logic [fatct_pkg::BANK_AW-1:0] CLR_LAST =
      fatct_pkg::BANK_AW'(fatct_pkg::BANK_DEPTH - 1);

   logic [fatct_pkg::BYTE_W-1:0] even_mem [fatct_pkg::BANK_DEPTH];
   logic [fatct_pkg::BYTE_W-1:0] odd_mem  [fatct_pkg::BANK_DEPTH];

   logic [fatct_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [fatct_pkg::CLUSTER_W-1:0] nv_ff, nv_in;
   logic [fatct_pkg::BADDR_W-1:0]   ba_ff, ba_in;
   logic [fatct_pkg::BYTE_W-1:0]    bd_ff, bd_in;
   logic [fatct_pkg::COUNT_W-1:0]   cur_ff, cur_in;
   logic [fatct_pkg::COUNT_W-1:0]   steps_ff, steps_in;
   logic [fatct_pkg::BANK_AW-1:0]   clr_ff, clr_in;
   logic [fatct_pkg::COUNT_W-1:0]   cc_ff, cc_in;
   logic [fatct_pkg::CLUSTER_W-1:0] cel_ff, cel_in;
   logic [fatct_pkg::BYTE_W-1:0]    rd_even_ff, rd_odd_ff;
   logic [fatct_pkg::CLUSTER_W-1:0] res_ev_ff, res_ev_in;
   logic [fatct_pkg::BYTE_W-1:0]    res_bv_ff, res_bv_in;
   logic [fatct_pkg::STATUS_W-1:0]  res_st_ff, res_st_in;
   logic [fatct_pkg::CLUSTER_W-1:0] out_ev_ff, out_ev_in;
   logic [fatct_pkg::BYTE_W-1:0]    out_bv_ff, out_bv_in;
   logic [fatct_pkg::STATUS_W-1:0]  out_st_ff, out_st_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [fatct_pkg::CLUSTER_W-1:0] ent_c;
   logic [fatct_pkg::BADDR_W-1:0]   off, off_hi;
   logic                            par, lo_ok, hi_ok, byte_ok;
   logic [15:0]                     word, new_word;
   logic [fatct_pkg::CLUSTER_W-1:0] entry, wv;
   logic [fatct_pkg::BYTE_W-1:0]    byte_sel;
   logic [fatct_pkg::COUNT_W-1:0]   eff_count;
   logic [fatct_pkg::BANK_AW-1:0]   ea, oa;
   logic                            e_ok, o_ok, ewe, owe;
   logic [fatct_pkg::BYTE_W-1:0]    ewd, owd;

   // entry c sits at byte c + c/2; odd offset means the low byte is in the odd bank
   always_comb begin
      ent_c   = cur_ff[fatct_pkg::CLUSTER_W-1:0];
      off     = {1'b0, ent_c} + {2'b00, ent_c[fatct_pkg::CLUSTER_W-1:1]};
      off_hi  = off + 13'd1;
      par     = off[0];
      lo_ok   = off < TB_LIMIT;
      hi_ok   = off_hi < TB_LIMIT;
      byte_ok = ba_ff < TB_LIMIT;
      word    = par ? {rd_even_ff, rd_odd_ff} : {rd_odd_ff, rd_even_ff};
      entry   = ent_c[0] ? word[15:4] : word[11:0];
      case (cmd_i.wr_val_sel)
         fatct_pkg::WV_NEXT: wv = nv_ff;
         fatct_pkg::WV_EOC:  wv = fatct_pkg::EOC_MARK;
         default:            wv = '0;
      endcase
      new_word  = ent_c[0] ? {wv, word[3:0]} : {word[15:12], wv};
      byte_sel  = ba_ff[0] ? rd_odd_ff : rd_even_ff;
      eff_count = (cc_ff > MAX_COUNT) ? MAX_COUNT : cc_ff;
   end

   always_comb begin
      if (cmd_i.mem_clear) begin
         ea   = clr_ff;
         oa   = clr_ff;
         e_ok = 1'b1;
         o_ok = 1'b1;
         ewe  = 1'b1;
         owe  = 1'b1;
         ewd  = '0;
         owd  = '0;
      end else if (cmd_i.wr_byte || cmd_i.addr_byte) begin
         ea   = ba_ff[fatct_pkg::BANK_AW:1];
         oa   = ba_ff[fatct_pkg::BANK_AW:1];
         e_ok = byte_ok;
         o_ok = byte_ok;
         ewe  = cmd_i.wr_byte && byte_ok && !ba_ff[0];
         owe  = cmd_i.wr_byte && byte_ok && ba_ff[0];
         ewd  = bd_ff;
         owd  = bd_ff;
      end else begin
         ea   = par ? off_hi[fatct_pkg::BANK_AW:1] : off[fatct_pkg::BANK_AW:1];
         oa   = off[fatct_pkg::BANK_AW:1];
         e_ok = par ? hi_ok : lo_ok;
         o_ok = par ? lo_ok : hi_ok;
         ewe  = cmd_i.wr_entry && e_ok;
         owe  = cmd_i.wr_entry && o_ok;
         ewd  = par ? new_word[15:8] : new_word[7:0];
         owd  = par ? new_word[7:0] : new_word[15:8];
      end
   end

   // bytes beyond the store read as zero
   always_ff @(posedge clock) begin
      if (ewe) even_mem[ea] <= ewd;
      if (cmd_i.mem_rd) rd_even_ff <= e_ok ? even_mem[ea] : '0;
   end

   always_ff @(posedge clock) begin
      if (owe) odd_mem[oa] <= owd;
      if (cmd_i.mem_rd) rd_odd_ff <= o_ok ? odd_mem[oa] : '0;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      nv_in        = nv_ff;
      ba_in        = ba_ff;
      bd_in        = bd_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      clr_in       = clr_ff;
      cc_in        = cc_ff;
      cel_in       = cel_ff;
      res_ev_in    = res_ev_ff;
      res_bv_in    = res_bv_ff;
      res_st_in    = res_st_ff;
      out_ev_in    = out_ev_ff;
      out_bv_in    = out_bv_ff;
      out_st_in    = out_st_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd_i.load_req) begin
         cmd_in   = req_cmd;
         nv_in    = req_next_value;
         ba_in    = req_byte_addr;
         bd_in    = req_byte_data;
         cur_in   = {1'b0, req_cluster};
         steps_in = '0;
      end
      if (cmd_i.cur_two)   cur_in = fatct_pkg::FIRST_DATA_CLUSTER;
      if (cmd_i.cur_inc)   cur_in = cur_ff + 13'd1;
      if (cmd_i.cur_next)  cur_in = {1'b0, entry};
      if (cmd_i.steps_inc) steps_in = steps_ff + 13'd1;
      if (cmd_i.mem_clear) clr_in = (clr_ff == CLR_LAST) ? '0 : clr_ff + 1'b1;

      if (csr_we) begin
         case (csr_index)
            fatct_pkg::CSR_CLUSTER_COUNT:   cc_in  = csr_data;
            fatct_pkg::CSR_CHAIN_END_LIMIT: cel_in = csr_data[fatct_pkg::CLUSTER_W-1:0];
            default: ;
         endcase
      end

      if (cmd_i.res_load) begin
         res_ev_in = '0;
         res_bv_in = '0;
         res_st_in = fatct_pkg::ST_OK;
         case (cmd_i.res_sel)
            fatct_pkg::RES_ENTRY:      res_ev_in = entry;
            fatct_pkg::RES_BYTE:       res_bv_in = byte_sel;
            fatct_pkg::RES_FREE:       res_ev_in = ent_c;
            fatct_pkg::RES_NO_FREE:    res_st_in = fatct_pkg::ST_NO_FREE;
            fatct_pkg::RES_STEP_LIMIT: res_st_in = fatct_pkg::ST_STEP_LIMIT;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd_i.out_load) begin
         out_ev_in    = res_ev_ff;
         out_bv_in    = res_bv_ff;
         out_st_in    = res_st_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      nv_ff     <= nv_in;
      ba_ff     <= ba_in;
      bd_ff     <= bd_in;
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      res_ev_ff <= res_ev_in;
      res_bv_ff <= res_bv_in;
      res_st_ff <= res_st_in;
      out_ev_ff <= out_ev_in;
      out_bv_ff <= out_bv_in;
      out_st_ff <= out_st_in;
      if (reset) begin
         clr_ff       <= '0;
         cc_ff        <= fatct_pkg::RESET_CLUSTER_COUNT;
         cel_ff       <= fatct_pkg::RESET_CHAIN_END;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         cc_ff        <= cc_in;
         cel_ff       <= cel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      sts_o.cmd             = cmd_ff;
      sts_o.clear_last      = clr_ff == CLR_LAST;
      sts_o.cur_below_count = cur_ff < eff_count;
      sts_o.entry_zero      = entry == '0;
      sts_o.chain_go        = (cur_ff >= fatct_pkg::FIRST_DATA_CLUSTER) &&
                              (cur_ff < {1'b0, cel_ff});
      sts_o.steps_at_limit  = steps_ff >= eff_count;
      sts_o.out_busy        = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = out_ev_ff;
   assign rsp_byte_value  = out_bv_ff;
   assign rsp_status      = out_st_ff;

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_i.out_load |=> rsp_valid_ff)
      else $error("response lost after load");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.mem_rd && !cmd_i.addr_byte) |-> !cur_ff[fatct_pkg::COUNT_W-1])
      else $error("entry read past the last cluster");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      cmd_i.load_req |-> (clr_ff == '0))
      else $error("request taken before clear pass finished");

endmodule

@@ design/fat12_cluster_table_engine_unit.sv @@
// Top level of the FAT12 cluster table engine: channels, sequencer, datapath.
// Depends on fatct_pkg, fatct_intf, fatct_ctrl and fatct_datapath.
//
// After reset the table is zeroed by a clearing pass over all 3072 bank rows (one even
// and one odd byte per cycle); requests wait until it ends, register writes are
// taken at any time. One request is worked at a time. Even and odd table bytes
// sit in two banks with registered reads, so both bytes of an entry come from a
// single read. Find free examines clusters upward from cluster 2 until it finds a
// free one or reaches the usable cluster count; free chain frees links until the
// walk ends on a chain end or on the step limit. Both loop a read and a check on
// the bank port for each cluster examined or link freed.
// The next request is accepted while a response still waits to be taken; its
// own response then stalls in the last cycle until the previous one has gone.
module fat12_cluster_table_engine_unit (
   input  logic        clock,
   input  logic        reset,
   fatct_req_if.sink   req_chan,
   fatct_rsp_if.source rsp_chan,
   fatct_csr_if.sink   csr_chan
);

   fatct_pkg::ctrl_cmd_type    ctrl_cmd;
   fatct_pkg::ctrl_status_type ctrl_sts;
   logic                       req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   fatct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (ctrl_sts),
      .cmd_o     (ctrl_cmd)
   );

   fatct_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_chan.cmd),
      .req_cluster     (req_chan.cluster),
      .req_next_value  (req_chan.next_value),
      .req_byte_addr   (req_chan.byte_addr),
      .req_byte_data   (req_chan.byte_data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_entry_value (rsp_chan.entry_value),
      .rsp_byte_value  (rsp_chan.byte_value),
      .rsp_status      (rsp_chan.status),
      .csr_we          (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .cmd_i           (ctrl_cmd),
      .sts_o           (ctrl_sts)
   );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for fat12_cluster_table_engine_unit: a directed request table,
// then randomised chain building and table traffic under a series of register settings.
// Depends on fatct_pkg, the channel interfaces of fatct_intf and the engine RTL.
module tb;
   import fatct_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_UNKNOWN   = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;
   localparam int STUCK_LIMIT = 60000;
   localparam int PRINT_CAP   = 200;
   localparam int PHASE_ITEMS = 180;
   localparam int NUM_PHASES  = 11;
   localparam int QUIET_PHASE = 4;
   localparam int SPARE_PHASE = 5;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [CLUSTER_W-1:0] cluster;
      logic [CLUSTER_W-1:0] next_value;
      logic [BADDR_W-1:0]   byte_addr;
      logic [BYTE_W-1:0]    byte_data;
   } fat_req_t;

   typedef struct packed {
      logic [CLUSTER_W-1:0] entry_value;
      logic [BYTE_W-1:0]    byte_value;
      logic [STATUS_W-1:0]  status;
   } fat_rsp_t;

   typedef struct packed {
      fat_req_t req;
      logic     typed;
      fat_rsp_t want;
   } dir_row_t;

   logic clock;
   logic reset;

   fatct_req_if req_chan ();
   fatct_rsp_if rsp_chan ();
   fatct_csr_if csr_chan ();

   fat12_cluster_table_engine_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predicted table image and register copies
   logic [BYTE_W-1:0]    fat_image [0:TABLE_BYTES-1];
   logic [COUNT_W-1:0]   cfg_count;
   logic [CLUSTER_W-1:0] cfg_chain_end;
   fat_rsp_t             resp_due [$];
   int                   fault_count = 0;
   int                   stuck_cycles = 0;
   bit                   idle_on = 1'b1;

   int phase_count [NUM_PHASES]     = '{4096, 8191, 0, 1, 2, 3, 4, 16, 100, 4096, 0};
   int phase_chain_end [NUM_PHASES] = '{4088, 4095, 4088, 2, 3000, 4095, 4088, 100, 4080,
                                        4088, 0};
   int phase_span [NUM_PHASES]      = '{48, 64, 16, 16, 24, 8, 12, 32, 96, 4000, 40};

   // Untyped rows take their expectation from the predictor
   dir_row_t dir_rows [26] = '{
      '{'{CMD_GET_NEXT,   12'd0,    12'd0,     13'd0,    8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_READ_BYTE,  12'd0,    12'd0,     13'd0,    8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_READ_BYTE,  12'd0,    12'd0,     13'd6143, 8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_FIND_FREE,  12'd0,    12'd0,     13'd0,    8'h00}, 1'b1, '{12'd2,   8'h00, ST_OK}},
      '{'{CMD_SET_NEXT,   12'd4095, 12'hFFF,   13'd0,    8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_READ_BYTE,  12'd0,    12'd0,     13'd6143, 8'h00}, 1'b1, '{12'd0,   8'hFF, ST_OK}},
      '{'{CMD_GET_NEXT,   12'd4095, 12'd0,     13'd0,    8'h00}, 1'b1, '{12'hFFF, 8'h00, ST_OK}},
      '{'{CMD_SET_NEXT,   12'd0,    12'hABC,   13'd0,    8'h00}, 1'b0, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_SET_NEXT,   12'd1,    12'h123,   13'd0,    8'h00}, 1'b0, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_GET_NEXT,   12'd0,    12'd0,     13'd0,    8'h00}, 1'b0, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_GET_NEXT,   12'd1,    12'd0,     13'd0,    8'h00}, 1'b0, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_WRITE_BYTE, 12'd0,    12'd0,     13'd8191, 8'hFF}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_READ_BYTE,  12'd0,    12'd0,     13'd8191, 8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_WRITE_BYTE, 12'd0,    12'd0,     13'd6144, 8'h55}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_READ_BYTE,  12'd0,    12'd0,     13'd6144, 8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_WRITE_BYTE, 12'd0,    12'd0,     13'd3,    8'hA5}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_READ_BYTE,  12'd0,    12'd0,     13'd3,    8'h00}, 1'b1, '{12'd0,   8'hA5, ST_OK}},
      '{'{CMD_UNKNOWN,    12'hFFF,  12'hFFF,   13'h1FFF, 8'hFF}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_SET_NEXT,   12'd2,    12'd3,     13'd0,    8'h00}, 1'b0, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_SET_NEXT,   12'd3,    12'd4,     13'd0,    8'h00}, 1'b0, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_SET_END,    12'd4,    12'd0,     13'd0,    8'h00}, 1'b0, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_FREE_CHAIN, 12'd2,    12'd0,     13'd0,    8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_GET_NEXT,   12'd3,    12'd0,     13'd0,    8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_GET_NEXT,   12'd4,    12'd0,     13'd0,    8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_FREE_CHAIN, 12'd4095, 12'd0,     13'd0,    8'h00}, 1'b1, '{12'd0,   8'h00, ST_OK}},
      '{'{CMD_FIND_FREE,  12'd0,    12'd0,     13'd0,    8'h00}, 1'b0, '{12'd0,   8'h00, ST_OK}}
   };

   function automatic logic [BYTE_W-1:0] image_rd(int unsigned a);
      return (a < TABLE_BYTES) ? fat_image[a] : '0;
   endfunction

   function automatic void image_wr(int unsigned a, logic [BYTE_W-1:0] v);
      if (a < TABLE_BYTES) fat_image[a] = v;
   endfunction

   // Entry c sits at byte c + c/2; odd entries take the high 12 bits of the word
   function automatic logic [CLUSTER_W-1:0] entry_at(logic [CLUSTER_W-1:0] c);
      int unsigned off;
      logic [15:0] w;
      off = 32'(c) + 32'(c) / 2;
      w = {image_rd(off + 1), image_rd(off)};
      return c[0] ? w[15:4] : w[11:0];
   endfunction

   function automatic void entry_put(logic [CLUSTER_W-1:0] c, logic [CLUSTER_W-1:0] v);
      int unsigned off;
      logic [15:0] w;
      off = 32'(c) + 32'(c) / 2;
      w = {image_rd(off + 1), image_rd(off)};
      if (c[0]) w = {v, w[3:0]};
      else w = {w[15:12], v};
      image_wr(off, w[7:0]);
      image_wr(off + 1, w[15:8]);
   endfunction

   function automatic int unsigned usable_clusters();
      return (cfg_count > MAX_CLUSTERS) ? MAX_CLUSTERS : 32'(cfg_count);
   endfunction

   function automatic fat_rsp_t fat_predict(fat_req_t r);
      fat_rsp_t res;
      int unsigned lim, steps, c;
      logic [CLUSTER_W-1:0] cur, nxt;
      res = '0;
      case (r.cmd)
         CMD_GET_NEXT:   res.entry_value = entry_at(r.cluster);
         CMD_SET_NEXT:   entry_put(r.cluster, r.next_value);
         CMD_SET_END:    entry_put(r.cluster, EOC_MARK);
         CMD_FIND_FREE: begin
            res.status = ST_NO_FREE;
            lim = usable_clusters();
            for (c = FIRST_DATA_CLUSTER; c < lim; c++) begin
               if (entry_at(c[CLUSTER_W-1:0]) == '0) begin
                  res.entry_value = c[CLUSTER_W-1:0];
                  res.status = ST_OK;
                  break;
               end
            end
         end
         CMD_FREE_CHAIN: begin
            lim = usable_clusters();
            steps = 0;
            cur = r.cluster;
            // each link is zeroed as it is walked, so a loop ends on its second pass
            while (cur >= FIRST_DATA_CLUSTER && cur < cfg_chain_end) begin
               if (steps >= lim) begin
                  res.status = ST_STEP_LIMIT;
                  break;
               end
               nxt = entry_at(cur);
               entry_put(cur, '0);
               cur = nxt;
               steps++;
            end
         end
         CMD_WRITE_BYTE: image_wr(r.byte_addr, r.byte_data);
         CMD_READ_BYTE:  res.byte_value = image_rd(r.byte_addr);
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      fault_count++;
      if (fault_count <= PRINT_CAP)
         $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic wait_drained();
      while (resp_due.size() != 0) @(negedge clock);
   endtask

   // Leaves valid high on return; the caller or the next request decides what follows
   task automatic send_request(fat_req_t r, logic typed, fat_rsp_t want);
      fat_rsp_t predicted;
      while (idle_on && $urandom_range(0, 99) < 10) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= r.cmd;
      req_chan.cluster    <= r.cluster;
      req_chan.next_value <= r.next_value;
      req_chan.byte_addr  <= r.byte_addr;
      req_chan.byte_data  <= r.byte_data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = fat_predict(r);
      resp_due.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      while (idle_on && $urandom_range(0, 99) < 10) begin
         csr_chan.valid <= 1'b0;
         @(negedge clock);
      end
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_CLUSTER_COUNT:   cfg_count = data;
         CSR_CHAIN_END_LIMIT: cfg_chain_end = data[CLUSTER_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic fat_req_t rand_req(logic [CMD_W-1:0] cmd);
      fat_req_t r;
      r.cmd        = cmd;
      r.cluster    = CLUSTER_W'($urandom_range(0, 4095));
      r.next_value = CLUSTER_W'($urandom_range(0, 4095));
      r.byte_addr  = BADDR_W'($urandom_range(0, 8191));
      r.byte_data  = BYTE_W'($urandom_range(0, 255));
      return r;
   endfunction

   // Mostly a small window near the start of the table, now and then anywhere
   function automatic logic [CLUSTER_W-1:0] pick_cluster(int span);
      if ($urandom_range(0, 9) == 0) return CLUSTER_W'($urandom_range(0, 4095));
      return CLUSTER_W'($urandom_range(0, span + 1));
   endfunction

   task automatic random_phase(int items, int span);
      int issued, len, i, pick;
      fat_req_t r;
      fat_rsp_t no_want;
      logic [CLUSTER_W-1:0] cur, head;
      logic [CMD_W-1:0] cmd;
      no_want = '0;
      issued = 0;
      while (issued < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // build a chain, usually terminate it, then read or free it from its head
            len = $urandom_range(1, 8);
            cur = pick_cluster(span);
            head = cur;
            for (i = 0; i < len; i++) begin
               r = rand_req(CMD_SET_NEXT);
               r.cluster = cur;
               r.next_value = pick_cluster(span);
               send_request(r, 1'b0, no_want);
               cur = r.next_value;
            end
            r = rand_req(($urandom_range(0, 9) < 7) ? CMD_SET_END : CMD_SET_NEXT);
            r.cluster = cur;
            send_request(r, 1'b0, no_want);
            r = rand_req($urandom_range(0, 1) ? CMD_FREE_CHAIN : CMD_GET_NEXT);
            r.cluster = head;
            send_request(r, 1'b0, no_want);
            issued += len + 2;
         end else begin
            if (pick < 60) cmd = CMD_GET_NEXT;
            else if (pick < 70) cmd = CMD_FIND_FREE;
            else if (pick < 78) cmd = CMD_FREE_CHAIN;
            else if (pick < 86) cmd = CMD_WRITE_BYTE;
            else if (pick < 94) cmd = CMD_READ_BYTE;
            else if (pick < 97) cmd = CMD_UNKNOWN;
            else cmd = CMD_SET_NEXT;
            r = rand_req(cmd);
            if (cmd == CMD_GET_NEXT || cmd == CMD_FREE_CHAIN) r.cluster = pick_cluster(span);
            if ($urandom_range(0, 1)) r.byte_addr = BADDR_W'($urandom_range(0, span * 2 + 4));
            send_request(r, 1'b0, no_want);
            issued++;
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !idle_on || ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin : rsp_check
      fat_rsp_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (resp_due.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_chan.entry_value, 0);
         end else begin
            want = resp_due.pop_front();
            if (rsp_chan.entry_value !== want.entry_value)
               report_mismatch("entry_value", rsp_chan.entry_value, want.entry_value);
            if (rsp_chan.byte_value !== want.byte_value)
               report_mismatch("byte_value", rsp_chan.byte_value, want.byte_value);
            if (rsp_chan.status !== want.status)
               report_mismatch("status", rsp_chan.status, want.status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         stuck_cycles = 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t TIMEOUT: no handshake for %0d cycles", $time, STUCK_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stuck_cycles++;
      end
   end

   initial begin
      int p;
      logic [COUNT_W-1:0]   cnt;
      logic [CLUSTER_W-1:0] lim;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = '0;
      req_chan.cluster    = '0;
      req_chan.next_value = '0;
      req_chan.byte_addr  = '0;
      req_chan.byte_data  = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = '0;
      csr_chan.data       = '0;
      rsp_chan.ready      = 1'b0;
      foreach (fat_image[a]) fat_image[a] = '0;
      cfg_count     = RESET_CLUSTER_COUNT;
      cfg_chain_end = RESET_CHAIN_END;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // requests stall here until the clearing pass is over
      foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
      req_chan.valid <= 1'b0;

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         repeat (4) @(negedge clock);
         idle_on = (p != QUIET_PHASE);
         if (p == NUM_PHASES - 1) begin
            cnt = COUNT_W'($urandom_range(2, MAX_CLUSTERS));
            lim = CLUSTER_W'($urandom_range(2, 4095));
         end else begin
            cnt = COUNT_W'(phase_count[p]);
            lim = CLUSTER_W'(phase_chain_end[p]);
         end
         write_csr(CSR_CLUSTER_COUNT, cnt);
         // top data bit is outside the chain end register and must be dropped
         write_csr(CSR_CHAIN_END_LIMIT, {1'($urandom_range(0, 1)), lim});
         if (p == SPARE_PHASE) write_csr(CSR_SPARE_IDX, CSR_DATA_W'($urandom_range(0, 8191)));
         csr_chan.valid <= 1'b0;
         random_phase(PHASE_ITEMS, phase_span[p]);
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (fault_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
